// ===== hw/rtl/sprite_entry_chain_expander_top_assert.svh =====
// Assertion macros shared by the sprite chain expander RTL.
`ifndef SPRITE_ENTRY_CHAIN_EXPANDER_TOP_ASSERT_SVH
`define SPRITE_ENTRY_CHAIN_EXPANDER_TOP_ASSERT_SVH

// Condition must hold in the same cycle as the trigger.
`define SECX_ASSERT_NOW(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("sprite chain expander: same-cycle check failed");

// Condition must hold in the cycle after the trigger.
`define SECX_ASSERT_NEXT(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("sprite chain expander: next-cycle check failed");

`endif

// ===== hw/rtl/secx_pkg.sv =====
// Types and constants for the sprite entry chain expander.
`default_nettype none

package secx_pkg;

  // Field widths
  localparam int unsigned TILE_W   = 16;
  localparam int unsigned COLOUR_W = 4;
  localparam int unsigned POS_W    = 8;
  localparam int unsigned ATTR_W   = 8;
  localparam int unsigned SX_W     = 10;
  localparam int unsigned SY_W     = 11;
  localparam int unsigned CHAIN_W  = 3;
  localparam int unsigned XOFF_W   = 5;
  localparam int unsigned CFG_DATA_W = 5;
  localparam int unsigned CFG_IDX_W  = 1;

  // Attribute byte layout
  localparam int unsigned ATTR_ENABLE = 0;
  localparam int unsigned ATTR_Y_HIGH = 1;
  localparam int unsigned ATTR_X_HIGH = 2;
  localparam int unsigned ATTR_FLIP_Y = 3;
  localparam int unsigned ATTR_FLIP_X = 4;
  localparam int unsigned ATTR_CHAIN_LSB = 5;

  // Position decode constants
  localparam logic [8:0]      X_WRAP_LIMIT = 9'd496;
  localparam logic [8:0]      Y_ORIGIN     = 9'd256;
  localparam logic [SY_W-1:0] TILE_H       = SY_W'(16);
  localparam logic [SX_W-1:0] FLIP_X_ORG   = SX_W'(304);
  localparam logic [SY_W-1:0] FLIP_Y_ORG   = SY_W'(240);

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SCREEN_FLIP = 1'b0,
    CFG_X_OFFSET    = 1'b1
  } secx_cfg_idx_t;

  // Decoded sprite entry, ready for chain stepping
  typedef struct packed {
    logic [TILE_W-1:0]   tile;
    logic [COLOUR_W-1:0] colour;
    logic                mirror_x;
    logic                mirror_y;
    logic [SX_W-1:0]     x;
    logic [SY_W-1:0]     y;
    logic                step_up;
    logic [CHAIN_W-1:0]  chain;
  } secx_entry_t;

  // Expander status seen by the top level
  typedef struct packed {
    logic               busy;
    logic               free;
    logic [CHAIN_W-1:0] index;
    logic [CHAIN_W-1:0] chain;
  } secx_status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/secx_decode.sv =====
// Position and flip decode of one sprite attribute entry.
`default_nettype none

module secx_decode (
  input  logic [secx_pkg::POS_W-1:0]    y_low,
  input  logic [secx_pkg::ATTR_W-1:0]   attributes,
  input  logic [secx_pkg::TILE_W-1:0]   tile_base,
  input  logic [secx_pkg::COLOUR_W-1:0] colour_bank,
  input  logic [secx_pkg::POS_W-1:0]    x_low,
  input  logic                          screen_flip,
  input  logic [secx_pkg::XOFF_W-1:0]   x_offset,
  output secx_pkg::secx_entry_t         entry
);
  import secx_pkg::*;

  logic [8:0]         x9;
  logic [8:0]         y9;
  logic [8:0]         y_dist;
  logic [SX_W-1:0]    x_wrap;
  logic [SX_W-1:0]    x_norm;
  logic [SY_W-1:0]    y_norm;
  logic [SY_W-1:0]    y_off;
  logic [SY_W-1:0]    y_base;
  logic [SY_W-1:0]    chain_span;
  logic [CHAIN_W-1:0] chain;
  logic               flip_x;
  logic               flip_y;
  logic               mir_y;

  // Nine-bit raw positions
  assign x9 = {attributes[ATTR_X_HIGH], x_low};
  assign y9 = {attributes[ATTR_Y_HIGH], y_low};

  // X wraps to negative above the limit; subtracting 512 sets bit 9
  assign x_wrap = {(x9 > X_WRAP_LIMIT), x9};
  assign x_norm = x_wrap + {{(SX_W-XOFF_W){x_offset[XOFF_W-1]}}, x_offset};

  // Y counts up from the bottom, taken modulo 512, then moved up one tile
  assign y_dist = Y_ORIGIN - y9;
  assign y_norm = {2'b00, y_dist} - TILE_H;
  assign y_off  = {{(SY_W-XOFF_W){x_offset[XOFF_W-1]}}, x_offset};

  assign chain  = attributes[ATTR_CHAIN_LSB +: CHAIN_W];
  assign flip_x = attributes[ATTR_FLIP_X];
  assign flip_y = attributes[ATTR_FLIP_Y];
  assign mir_y  = flip_y ^ screen_flip;
  assign chain_span = {{(SY_W-CHAIN_W-4){1'b0}}, chain, 4'b0000};

  // Screen flip mirrors both axes
  assign y_base = screen_flip ? (FLIP_Y_ORG - y_norm - y_off) : y_norm;

  always_comb begin
    entry.tile     = tile_base;
    entry.colour   = colour_bank;
    entry.mirror_x = flip_x ^ screen_flip;
    entry.mirror_y = mir_y;
    entry.x        = screen_flip ? (FLIP_X_ORG - x_norm) : x_norm;
    entry.step_up  = mir_y;
    entry.chain    = chain;
    // Chain start: the first tile sits at the far end of the chain for two cases
    if (!screen_flip && flip_y) begin
      entry.y = y_base - chain_span;
    end else if (screen_flip && !mir_y) begin
      entry.y = y_base + chain_span;
    end else begin
      entry.y = y_base;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/secx_expand.sv =====
// Chain stepper: holds one decoded entry and emits one tile per cycle while the output is not stalled.
`default_nettype none

module secx_expand (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          load,
  input  secx_pkg::secx_entry_t         entry_in,
  input  logic                          out_stall,
  output logic                          out_valid,
  output logic [secx_pkg::TILE_W-1:0]   tile_number,
  output logic [secx_pkg::COLOUR_W-1:0] tile_colour,
  output logic                          mirror_x,
  output logic                          mirror_y,
  output logic [secx_pkg::SX_W-1:0]     screen_x,
  output logic [secx_pkg::SY_W-1:0]     screen_y,
  output logic                          last_tile,
  output secx_pkg::secx_status_t        status
);
  import secx_pkg::*;

  secx_entry_t        ent;
  logic               busy;
  logic [CHAIN_W-1:0] index;
  logic               advance;
  logic               at_last;

  // Output register moves when empty or taken
  assign advance = !out_valid || !out_stall;
  assign at_last = (index == ent.chain);

  assign status.busy  = busy;
  assign status.free  = !busy || (advance && at_last);
  assign status.index = index;
  assign status.chain = ent.chain;

  // Control: entry occupancy, tile index, output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      index     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (advance) begin
        out_valid <= busy;
      end
      if (load) begin
        busy  <= 1'b1;
        index <= '0;
      end else if (busy && advance) begin
        if (at_last) begin
          busy  <= 1'b0;
          index <= '0;
        end else begin
          index <= index + CHAIN_W'(1);
        end
      end
    end
  end

  // Entry payload: load fresh, or step tile and Y after each emitted tile
  always_ff @(posedge clk) begin
    if (load) begin
      ent <= entry_in;
    end else if (busy && advance) begin
      ent.tile <= ent.tile + TILE_W'(1);
      ent.y    <= ent.step_up ? (ent.y + TILE_H) : (ent.y - TILE_H);
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (busy && advance) begin
      tile_number <= ent.tile;
      tile_colour <= ent.colour;
      mirror_x    <= ent.mirror_x;
      mirror_y    <= ent.mirror_y;
      screen_x    <= ent.x;
      screen_y    <= ent.y;
      last_tile   <= at_last;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/sprite_entry_chain_expander_top.sv =====
// An enabled entry is loaded into the stepper, then its first tile moves into the output register.
// An enabled entry emits chain + 1 tiles (1 to 8), one tile per cycle while out_stall is low,
// through the output register; a disabled entry is accepted and emits nothing.
// The next entry is accepted in the cycle the current entry's last tile is registered.
// Reset (rst, synchronous) empties the stepper and output and clears both config registers.
`default_nettype none

module sprite_entry_chain_expander_top (
  input  logic                                clk,
  input  logic                                rst,
  // Config write port
  input  logic                                cfg_write,
  input  logic [secx_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [secx_pkg::CFG_DATA_W-1:0]     cfg_data,
  // Entry channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [secx_pkg::POS_W-1:0]          y_low,
  input  logic [secx_pkg::ATTR_W-1:0]         attributes,
  input  logic [secx_pkg::TILE_W-1:0]         tile_base,
  input  logic [secx_pkg::COLOUR_W-1:0]       colour_bank,
  input  logic [secx_pkg::POS_W-1:0]          x_low,
  // Tile command channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [secx_pkg::TILE_W-1:0]         tile_number,
  output logic [secx_pkg::COLOUR_W-1:0]       tile_colour,
  output logic                                mirror_x,
  output logic                                mirror_y,
  output logic signed [secx_pkg::SX_W-1:0]    screen_x,
  output logic signed [secx_pkg::SY_W-1:0]    screen_y,
  output logic                                last_tile
);
  import secx_pkg::*;

  `include "sprite_entry_chain_expander_top_assert.svh"

  logic               screen_flip;
  logic [XOFF_W-1:0]  x_offset;
  logic               accept;
  logic               load;
  secx_entry_t        entry;
  secx_status_t       st;
  logic [SX_W-1:0]    sx_raw;
  logic [SY_W-1:0]    sy_raw;

  // Config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      screen_flip <= 1'b0;
      x_offset    <= '0;
    end else if (cfg_write) begin
      unique case (secx_cfg_idx_t'(cfg_index))
        CFG_SCREEN_FLIP: screen_flip <= cfg_data[0];
        CFG_X_OFFSET:    x_offset    <= cfg_data[XOFF_W-1:0];
        default: ;
      endcase
    end
  end

  // Input transaction; disabled entries are dropped
  assign in_stall = !st.free;
  assign accept   = in_valid && !in_stall;
  assign load     = accept && attributes[ATTR_ENABLE];

  secx_decode u_decode (
    .y_low       (y_low),
    .attributes  (attributes),
    .tile_base   (tile_base),
    .colour_bank (colour_bank),
    .x_low       (x_low),
    .screen_flip (screen_flip),
    .x_offset    (x_offset),
    .entry       (entry)
  );

  secx_expand u_expand (
    .clk         (clk),
    .rst         (rst),
    .load        (load),
    .entry_in    (entry),
    .out_stall   (out_stall),
    .out_valid   (out_valid),
    .tile_number (tile_number),
    .tile_colour (tile_colour),
    .mirror_x    (mirror_x),
    .mirror_y    (mirror_y),
    .screen_x    (sx_raw),
    .screen_y    (sy_raw),
    .last_tile   (last_tile),
    .status      (st)
  );

  assign screen_x = signed'(sx_raw);
  assign screen_y = signed'(sy_raw);

  // A loaded entry starts at its first tile
  `SECX_ASSERT_NEXT(a_load_starts_chain, load, st.busy && (st.index == '0))
  // Tile index never passes the chain length
  `SECX_ASSERT_NOW(a_index_in_chain, st.busy, st.index <= st.chain)
  // With nothing in the stepper, a taken result leaves the output empty
  `SECX_ASSERT_NEXT(a_drain_empties, out_valid && !out_stall && !st.busy, !out_valid)

endmodule

`default_nettype wire

// ===== tb/tb_sprite_entry_chain_expander_top.sv =====
// Self-checking testbench: sprite entries in, predicted tile commands compared on the way out.
`timescale 1ns / 100ps

module tb_sprite_entry_chain_expander_top;
  import secx_pkg::*;

  localparam int WATCHDOG_LIMIT = 1000;
  localparam int MAX_REPORTS    = 10;

  // One tile draw command as seen on the output channel
  typedef struct packed {
    logic [TILE_W-1:0]        tile_number;
    logic [COLOUR_W-1:0]      tile_colour;
    logic                     mirror_x;
    logic                     mirror_y;
    logic signed [SX_W-1:0]   screen_x;
    logic signed [SY_W-1:0]   screen_y;
    logic                     last_tile;
  } tile_cmd_t;

  // Receiver stall behaviors
  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_RANDOM,
    STALL_SPARSE,
    STALL_HEAVY
  } stall_mode_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_SCREEN_FLIP;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [POS_W-1:0]      y_low = '0;
  logic [ATTR_W-1:0]     attributes = '0;
  logic [TILE_W-1:0]     tile_base = '0;
  logic [COLOUR_W-1:0]   colour_bank = '0;
  logic [POS_W-1:0]      x_low = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [TILE_W-1:0]     tile_number;
  logic [COLOUR_W-1:0]   tile_colour;
  logic                  mirror_x;
  logic                  mirror_y;
  logic signed [SX_W-1:0] screen_x;
  logic signed [SY_W-1:0] screen_y;
  logic                  last_tile;

  // Predictor copy of the configuration registers
  logic                     model_flip = 1'b0;
  logic signed [XOFF_W-1:0] model_x_offset = '0;

  tile_cmd_t   expected_tiles[$];
  int          failures = 0;
  int          idle_cycles = 0;
  int          burst_left = 4;
  int          stall_tick = 0;
  stall_mode_t stall_mode = STALL_NONE;

  sprite_entry_chain_expander_top uut (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .y_low       (y_low),
    .attributes  (attributes),
    .tile_base   (tile_base),
    .colour_bank (colour_bank),
    .x_low       (x_low),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .tile_number (tile_number),
    .tile_colour (tile_colour),
    .mirror_x    (mirror_x),
    .mirror_y    (mirror_y),
    .screen_x    (screen_x),
    .screen_y    (screen_y),
    .last_tile   (last_tile)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Build an attribute byte from its fields
  function automatic logic [ATTR_W-1:0] make_attr(bit enable, logic [CHAIN_W-1:0] chain,
                                                  bit flip_x, bit flip_y,
                                                  bit x_high, bit y_high);
    logic [ATTR_W-1:0] a;
    a = '0;
    a[ATTR_ENABLE] = enable;
    a[ATTR_Y_HIGH] = y_high;
    a[ATTR_X_HIGH] = x_high;
    a[ATTR_FLIP_Y] = flip_y;
    a[ATTR_FLIP_X] = flip_x;
    a[ATTR_CHAIN_LSB +: CHAIN_W] = chain;
    return a;
  endfunction

  // Expand one accepted entry into the tile commands it should produce
  function automatic void expand_entry(logic [POS_W-1:0] y, logic [ATTR_W-1:0] attr,
                                       logic [TILE_W-1:0] tile, logic [COLOUR_W-1:0] colour,
                                       logic [POS_W-1:0] x);
    int        xpos;
    int        ypos;
    int        ty;
    int        chain;
    bit        fx;
    bit        fy;
    tile_cmd_t cmd;
    if (!attr[ATTR_ENABLE]) return;
    // 9-bit X with wrap near the right edge, then offset
    xpos = int'({attr[ATTR_X_HIGH], x});
    if (xpos > 496) xpos -= 512;
    xpos += int'(model_x_offset);
    // Y counts up from the bottom of a 512-line space
    ypos = (256 - int'({attr[ATTR_Y_HIGH], y})) & 'h1ff;
    ypos -= 16;
    fx = attr[ATTR_FLIP_X];
    fy = attr[ATTR_FLIP_Y];
    chain = int'(attr[ATTR_CHAIN_LSB +: CHAIN_W]);
    if (model_flip) begin
      fx = !fx;
      fy = !fy;
      ypos = 240 - ypos - int'(model_x_offset);
      xpos = 304 - xpos;
    end
    for (int k = 0; k <= chain; k++) begin
      if (model_flip) begin
        ty = fy ? ypos + 16 * k : ypos + 16 * (chain - k);
      end else begin
        ty = fy ? ypos - 16 * chain + 16 * k : ypos - 16 * k;
      end
      cmd.tile_number = tile + k[TILE_W-1:0];
      cmd.tile_colour = colour;
      cmd.mirror_x    = fx;
      cmd.mirror_y    = fy;
      cmd.screen_x    = xpos[SX_W-1:0];
      cmd.screen_y    = ty[SY_W-1:0];
      cmd.last_tile   = (k == chain);
      expected_tiles.push_back(cmd);
    end
  endfunction

  function automatic string fmt_tile(tile_cmd_t c);
    return $sformatf("tile %h colour %h mx %b my %b x %0d y %0d last %b",
                     c.tile_number, c.tile_colour, c.mirror_x, c.mirror_y,
                     $signed(c.screen_x), $signed(c.screen_y), c.last_tile);
  endfunction

  // Send one entry; the sender pauses between bursts of random length
  task automatic send_entry(logic [POS_W-1:0] y, logic [ATTR_W-1:0] attr,
                            logic [TILE_W-1:0] tile, logic [COLOUR_W-1:0] colour,
                            logic [POS_W-1:0] x);
    in_valid    <= 1'b1;
    y_low       <= y;
    attributes  <= attr;
    tile_base   <= tile;
    colour_bank <= colour;
    x_low       <= x;
    do @(posedge clk); while (in_stall);
    expand_entry(y, attr, tile, colour, x);
    burst_left--;
    if (burst_left <= 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 5) == 0) ? 40 : $urandom_range(1, 10);
    end
  endtask

  // Stop sending and let every expected tile command arrive
  task automatic wait_for_idle();
    in_valid <= 1'b0;
    while (expected_tiles.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write both registers back to back while the block is idle
  task automatic set_config(bit flip, int xoff);
    wait_for_idle();
    cfg_write <= 1'b1;
    cfg_index <= CFG_SCREEN_FLIP;
    cfg_data  <= CFG_DATA_W'(flip);
    @(posedge clk);
    model_flip = flip;
    cfg_index <= CFG_X_OFFSET;
    cfg_data  <= xoff[CFG_DATA_W-1:0];
    @(posedge clk);
    model_x_offset = xoff[XOFF_W-1:0];
    cfg_write <= 1'b0;
  endtask

  // Every chain length, with a tile base that wraps on the longer chains
  task automatic test_chain_lengths();
    logic [CHAIN_W-1:0] c;
    set_config(1'b0, 0);
    for (int i = 0; i < 8; i++) begin
      c = i[CHAIN_W-1:0];
      send_entry(8'h40 + 8'(i), make_attr(1'b1, c, c[0], c[1], 1'b0, 1'b0),
                 16'hfffc, COLOUR_W'(i), 8'h80);
    end
  endtask

  // Disabled entries must not produce anything, whatever their other bits say
  task automatic test_disabled_entries();
    send_entry(8'hff, make_attr(1'b0, 3'd7, 1'b1, 1'b1, 1'b1, 1'b1), 16'hffff, 4'hf, 8'hff);
    send_entry(8'h10, make_attr(1'b1, 3'd0, 1'b0, 1'b0, 1'b0, 1'b0), 16'h1234, 4'h5, 8'h20);
    send_entry(8'h00, '0, 16'h0000, 4'h0, 8'h00);
  endtask

  // Position decode corners: X wrap boundary, both Y high values, both offset extremes
  task automatic test_position_extremes();
    set_config(1'b0, 15);
    send_entry(8'h00, make_attr(1'b1, 3'd0, 1'b0, 1'b0, 1'b0, 1'b0), 16'h0000, 4'h0, 8'h00);
    send_entry(8'h00, make_attr(1'b1, 3'd7, 1'b1, 1'b0, 1'b1, 1'b1), 16'hffff, 4'hf, 8'hff);
    send_entry(8'hff, make_attr(1'b1, 3'd2, 1'b0, 1'b1, 1'b1, 1'b1), 16'h8000, 4'ha, 8'hf0);
    send_entry(8'hff, make_attr(1'b1, 3'd1, 1'b1, 1'b1, 1'b1, 1'b0), 16'h7fff, 4'h5, 8'hf1);
    set_config(1'b0, -16);
    send_entry(8'h00, make_attr(1'b1, 3'd3, 1'b0, 1'b0, 1'b0, 1'b0), 16'h00ff, 4'h3, 8'h00);
    send_entry(8'hff, make_attr(1'b1, 3'd7, 1'b0, 1'b1, 1'b1, 1'b1), 16'hfff9, 4'hc, 8'hf1);
  endtask

  // Flipped screen: mirrored coordinates and inverted flips at both offset extremes
  task automatic test_screen_flip();
    set_config(1'b1, -16);
    send_entry(8'h00, make_attr(1'b1, 3'd0, 1'b0, 1'b0, 1'b0, 1'b0), 16'h0100, 4'h1, 8'h00);
    send_entry(8'hff, make_attr(1'b1, 3'd7, 1'b1, 1'b1, 1'b1, 1'b1), 16'hfffe, 4'hf, 8'hff);
    send_entry(8'h80, make_attr(1'b1, 3'd3, 1'b0, 1'b1, 1'b1, 1'b0), 16'h4242, 4'h7, 8'hf0);
    send_entry(8'h01, make_attr(1'b1, 3'd1, 1'b1, 1'b0, 1'b0, 1'b1), 16'h0001, 4'h8, 8'h01);
    set_config(1'b1, 15);
    send_entry(8'h00, make_attr(1'b1, 3'd7, 1'b0, 1'b0, 1'b1, 1'b1), 16'h0000, 4'h0, 8'hff);
    send_entry(8'hff, make_attr(1'b1, 3'd5, 1'b1, 1'b1, 1'b0, 1'b0), 16'hffff, 4'hf, 8'h00);
    send_entry(8'hf0, make_attr(1'b1, 3'd2, 1'b0, 1'b1, 1'b1, 1'b0), 16'h1111, 4'h9, 8'hf1);
  endtask

  // Random entries over several configurations, extremes among them
  task automatic test_random_entries();
    int                  phase_flip[7] = '{0, 1, 0, 1, 0, 1, 0};
    int                  phase_xoff[7] = '{0, -16, 15, 15, -16, 0, 0};
    int                  enabled;
    logic [ATTR_W-1:0]   attr;
    logic [POS_W-1:0]    x;
    logic [TILE_W-1:0]   tile;
    phase_xoff[5] = $urandom_range(0, 31) - 16;
    phase_xoff[6] = $urandom_range(0, 31) - 16;
    for (int p = 0; p < 7; p++) begin
      set_config(phase_flip[p][0], phase_xoff[p]);
      enabled = 0;
      while (enabled < 29) begin
        attr = ATTR_W'($urandom_range(0, 255));
        attr[ATTR_ENABLE] = ($urandom_range(0, 99) < 85);
        if (attr[ATTR_ENABLE]) enabled++;
        x = POS_W'($urandom_range(0, 255));
        // lean on the X wrap boundary and the tile number wrap now and then
        if ($urandom_range(0, 7) == 0) x = 8'hef + 8'($urandom_range(0, 3));
        tile = TILE_W'($urandom_range(0, 65535));
        if ($urandom_range(0, 7) == 0) tile = 16'hfff8 + 16'($urandom_range(0, 7));
        send_entry(POS_W'($urandom_range(0, 255)), attr, tile,
                   COLOUR_W'($urandom_range(0, 15)), x);
      end
    end
  endtask

  // Receiver stall pattern, picked at random each time the low six bits of stall_tick reach 63
  always @(posedge clk) begin
    stall_tick <= stall_tick + 1;
    if (stall_tick[5:0] == 6'd63) stall_mode <= stall_mode_t'($urandom_range(0, 3));
    case (stall_mode)
      STALL_NONE:   out_stall <= 1'b0;
      STALL_RANDOM: out_stall <= ($urandom_range(0, 99) < 35);
      STALL_SPARSE: out_stall <= (stall_tick[1:0] == 2'd3);
      default:      out_stall <= (stall_tick[3:0] < 4'd9);
    endcase
  end

  // Compare each output transaction with the oldest expected tile command
  always @(posedge clk) begin
    tile_cmd_t got;
    tile_cmd_t want;
    if (!rst && out_valid && !out_stall) begin
      got = '{tile_number, tile_colour, mirror_x, mirror_y, screen_x, screen_y, last_tile};
      if (expected_tiles.size() == 0) begin
        failures++;
        if (failures <= MAX_REPORTS) $display("unexpected tile command: %s", fmt_tile(got));
      end else begin
        want = expected_tiles.pop_front();
        if (got !== want) begin
          failures++;
          if (failures <= MAX_REPORTS)
            $display("tile mismatch: expected %s, got %s", fmt_tile(want), fmt_tile(got));
        end
      end
    end
  end

  // Watchdog: count cycles with no transaction on either channel
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    wait (idle_cycles >= WATCHDOG_LIMIT);
    $display("FAIL sprite_entry_chain_expander_top");
    $finish;
  end

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_chain_lengths();
    test_disabled_entries();
    test_position_extremes();
    test_screen_flip();
    test_random_entries();
    wait_for_idle();
    repeat (16) @(posedge clk);
    if (failures == 0 && expected_tiles.size() == 0) begin
      $display("PASS sprite_entry_chain_expander_top");
    end else begin
      $display("FAIL sprite_entry_chain_expander_top");
    end
    $finish;
  end

endmodule
